[rtl/core/integer_to_radix_string_core_assert.svh]
// Assertion macros for the radix string core.
`ifndef INTEGER_TO_RADIX_STRING_CORE_ASSERT_SVH
`define INTEGER_TO_RADIX_STRING_CORE_ASSERT_SVH

// Check cons in the same cycle as ante.
`define I2RS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check cons in the cycle after ante.
`define I2RS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/i2rs_pkg.sv]
// Shared types and constants for the radix string core.
package i2rs_pkg;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 64;
  localparam int RADIX_BITS     = 6;
  localparam int CHAR_BITS      = 8;
  localparam int ALPHA_BITS     = 256;

  localparam logic [CFG_INDEX_BITS-1:0] REG_RADIX  = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ALPHA0 = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ALPHA1 = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ALPHA2 = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ALPHA3 = 3'd4;

  localparam logic [RADIX_BITS-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_BITS-1:0] ALPHA_LIMIT = 6'd32;

  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctl_t;

endpackage

[rtl/core/i2rs_cell.sv]
// One digit cell: doubles its digit with carry in base radix, or shifts to its neighbor.
module i2rs_cell import i2rs_pkg::*; #(
  parameter int DIGIT_BITS = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cell_ctl_t             ctl,
  input  logic [DIGIT_BITS:0]   radix,
  input  logic                  en_in,
  input  logic                  cin,
  input  logic [DIGIT_BITS-1:0] shift_in,
  output logic                  en_out,
  output logic                  cout,
  output logic [DIGIT_BITS-1:0] digit
);

  logic [DIGIT_BITS:0] sum;
  logic [DIGIT_BITS:0] diff;
  logic                ge;

  assign sum  = {digit, cin};
  assign ge   = (sum >= radix);
  assign diff = sum - radix;

  always_ff @(posedge clk) begin
    if (rst) begin
      en_out <= 1'b0;
      cout   <= 1'b0;
    end else begin
      en_out <= en_in & ~ctl.clear;
      cout   <= en_in & ge & ~ctl.clear;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      digit <= '0;
    end else if (en_in) begin
      digit <= ge ? diff[DIGIT_BITS-1:0] : sum[DIGIT_BITS-1:0];
    end else if (ctl.shift) begin
      digit <= shift_in;
    end
  end

endmodule

[rtl/core/integer_to_radix_string_core.sv]
// Integer to radix string converter: systolic row of base-radix digit cells.
// Conversion: bits enter one per cycle and carries move one cell per cycle through the
// row; leading zero digits are then shifted out (at least one digit stays), and the N
// characters leave one per cycle while the output is not stalled.
// One item at a time; s_tready is high only when idle.
// Reset (synchronous, rst high): radix 10, alphabet all zero, idle, no output valid.
module integer_to_radix_string_core import i2rs_pkg::*; #(
  parameter int MAX_RADIX  = 32,
  parameter int VALUE_BITS = 63
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [63:0]               s_tdata,   // [62:0] value
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [7:0]                m_tdata,   // [7:0] digit_char
  output logic                      m_tlast,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int DW    = $clog2(MAX_RADIX);
  localparam int RW    = DW + 1;
  localparam int NCELL = VALUE_BITS;
  localparam int CW    = $clog2(2 * VALUE_BITS);
  localparam int REMW  = $clog2(VALUE_BITS + 1);
  localparam logic [RADIX_BITS-1:0] TOP_RADIX = RADIX_BITS'((MAX_RADIX > 63) ? 63 : MAX_RADIX);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SKIP = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]              state;
  logic [CW-1:0]           cnt;
  logic [REMW-1:0]         rem;
  logic [VALUE_BITS-1:0]   shreg;
  logic [RADIX_BITS-1:0]   radix_reg;
  logic [CFG_DATA_BITS-1:0] alpha0, alpha1, alpha2, alpha3;
  logic [ALPHA_BITS-1:0]   alpha;
  logic [RADIX_BITS-1:0]   radix_clamp;
  logic [RW-1:0]           radix_eff;
  logic                    accept;
  logic                    emit_fire;
  logic                    skip_shift;
  cell_ctl_t               ctl;
  logic [5:0]              digit6;
  logic [CHAR_BITS-1:0]    char_sel;

  logic                    en_chain    [NCELL+1];
  logic                    carry_chain [NCELL+1];
  logic [DW-1:0]           digits      [NCELL];
  logic [DW-1:0]           shift_src   [NCELL];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      radix_reg <= RADIX_RESET;
      alpha0    <= '0;
      alpha1    <= '0;
      alpha2    <= '0;
      alpha3    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RADIX:  radix_reg <= cfg_data[RADIX_BITS-1:0];
        REG_ALPHA0: alpha0 <= cfg_data;
        REG_ALPHA1: alpha1 <= cfg_data;
        REG_ALPHA2: alpha2 <= cfg_data;
        REG_ALPHA3: alpha3 <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (radix_reg < RADIX_MIN) begin
      radix_clamp = RADIX_MIN;
    end else if (radix_reg > TOP_RADIX) begin
      radix_clamp = TOP_RADIX;
    end else begin
      radix_clamp = radix_reg;
    end
  end

  assign radix_eff = RW'(radix_clamp);
  assign alpha     = {alpha3, alpha2, alpha1, alpha0};

  assign s_tready   = (state == ST_IDLE);
  assign accept     = s_tvalid & s_tready;
  assign emit_fire  = (state == ST_EMIT) & (~m_tvalid | m_tready);
  assign skip_shift = (state == ST_SKIP) & (rem != REMW'(1)) & (digits[NCELL-1] == '0);
  assign ctl.clear  = accept;
  assign ctl.shift  = emit_fire | skip_shift;

  assign en_chain[0]    = (state == ST_CONV) & (cnt < CW'(VALUE_BITS));
  assign carry_chain[0] = shreg[VALUE_BITS-1];

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign shift_src[i] = '0;
    end else begin : g_rest
      assign shift_src[i] = digits[i-1];
    end
    i2rs_cell #(.DIGIT_BITS(DW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .radix    (radix_eff),
      .en_in    (en_chain[i]),
      .cin      (carry_chain[i]),
      .shift_in (shift_src[i]),
      .en_out   (en_chain[i+1]),
      .cout     (carry_chain[i+1]),
      .digit    (digits[i])
    );
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      rem   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_CONV;
            cnt   <= '0;
            rem   <= REMW'(VALUE_BITS);
          end
        end
        ST_CONV: begin
          cnt <= cnt + CW'(1);
          if (cnt == CW'(2 * VALUE_BITS - 2)) begin
            state <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          if (skip_shift) begin
            rem <= rem - REMW'(1);
          end else begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_fire) begin
            rem <= rem - REMW'(1);
            if (rem == REMW'(1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      shreg <= s_tdata[VALUE_BITS-1:0];
    end else if (state == ST_CONV) begin
      shreg <= {shreg[VALUE_BITS-2:0], 1'b0};
    end
  end

  assign digit6   = 6'(digits[NCELL-1]);
  assign char_sel = (digit6 >= ALPHA_LIMIT) ? '0 : alpha[{digit6[4:0], 3'b000} +: CHAR_BITS];

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      m_tdata <= char_sel;
      m_tlast <= (rem == REMW'(1));
    end
  end

`include "integer_to_radix_string_core_assert.svh"

  `I2RS_ASSERT_IMPL(a_no_overflow, 1'b1, !carry_chain[NCELL], "carry left the top cell")
  `I2RS_ASSERT_IMPL(a_idle_quiet, state == ST_IDLE, !en_chain[NCELL], "cell row active while idle")
  `I2RS_ASSERT_NEXT(a_last_out, emit_fire && (rem == REMW'(1)), m_tvalid && m_tlast, "final transfer not flagged")

endmodule

[tb/tb.sv]
// Testbench for integer_to_radix_string_core: directed and random values checked digit by digit.
module tb;
  import i2rs_pkg::*;

  localparam int MAX_RADIX  = 32;
  localparam int VALUE_BITS = 63;
  localparam int LONG_HOLD  = 600;
  localparam logic [ALPHA_BITS-1:0] DIGITS =
    {"VUTSRQPO", "NMLKJIHG", "FEDCBA98", "76543210"};

  typedef struct packed {
    logic [CHAR_BITS-1:0] ch;
    logic                 last;
  } char_t;

  typedef struct {
    logic [RADIX_BITS-1:0] radix;
    logic [ALPHA_BITS-1:0] alpha;
    bit                    junk;
  } setting_t;

  typedef struct {
    int                   cfg;
    logic [63:0]          word;
    int                   typed_n;
    logic [CHAR_BITS-1:0] typed_ch;
  } row_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [63:0]               s_tdata = '0;       // [62:0] value
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [7:0]                m_tdata;            // [7:0] digit_char
  logic                      m_tlast;
  logic                      cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = REG_RADIX;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  logic [RADIX_BITS-1:0] model_radix = RADIX_RESET;
  logic [ALPHA_BITS-1:0] model_alpha = '0;
  char_t                 expected_chars[$];
  char_t                 want;
  int                    bad_chars = 0;
  bit                    sender_calm = 1'b0;
  bit                    want_long_hold = 1'b0;

  setting_t presets [9] = '{
    '{RADIX_RESET, '0, 1'b0},
    '{6'd2, DIGITS, 1'b0},
    '{6'd16, DIGITS, 1'b0},
    '{6'd32, DIGITS, 1'b1},
    '{6'd0, DIGITS, 1'b0},
    '{6'd63, DIGITS, 1'b0},
    '{6'd1, ~DIGITS, 1'b0},
    '{6'd33, DIGITS, 1'b0},
    '{6'd10, {ALPHA_BITS{1'b1}}, 1'b1}
  };

  row_t rows [25] = '{
    '{0, 64'd0, 1, 8'h00},
    '{0, 64'd1000000, 7, 8'h00},
    '{0, 64'hFFFF_FFFF_FFFF_FFFF, 19, 8'h00},
    '{1, 64'd0, 1, "0"},
    '{1, 64'h7FFF_FFFF_FFFF_FFFF, 63, "1"},
    '{1, 64'h8000_0000_0000_0001, 1, "1"},
    '{1, 64'h4000_0000_0000_0000, 0, 8'h00},
    '{1, 64'h5555_5555_5555_5555, 0, 8'h00},
    '{2, 64'hFEDC_BA98_7654_3210, 0, 8'h00},
    '{2, 64'h7FFF_FFFF_FFFF_FFFF, 0, 8'h00},
    '{2, 64'd15, 1, "F"},
    '{3, 64'h7FFF_FFFF_FFFF_FFFF, 0, 8'h00},
    '{3, 64'd31, 1, "V"},
    '{3, 64'd32, 0, 8'h00},
    '{3, 64'd0, 1, "0"},
    '{4, 64'h2AAA_AAAA_AAAA_AAAA, 0, 8'h00},
    '{4, 64'd6, 0, 8'h00},
    '{5, 64'd1023, 0, 8'h00},
    '{5, 64'h7FFF_FFFF_FFFF_FFFF, 0, 8'h00},
    '{6, 64'd9, 0, 8'h00},
    '{6, 64'h7FFF_FFFF_FFFF_FFFF, 63, 8'hCE},
    '{7, 64'h0123_4567_89AB_CDEF, 0, 8'h00},
    '{7, 64'd33, 0, 8'h00},
    '{8, 64'h7FFF_FFFF_FFFF_FFFF, 19, 8'hFF},
    '{8, 64'd0, 1, 8'hFF}
  };

  integer_to_radix_string_core #(
    .MAX_RADIX (MAX_RADIX),
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void queue_char(input logic [CHAR_BITS-1:0] ch, input logic last);
    char_t c;
    c.ch = ch;
    c.last = last;
    expected_chars.insert(expected_chars.size(), c);
  endfunction

  function automatic logic [CHAR_BITS-1:0] digit_char_of(input int digit);
    if (digit >= ALPHA_LIMIT) return '0;
    return model_alpha[digit*CHAR_BITS +: CHAR_BITS];
  endfunction

  function automatic void predict_digits(input logic [VALUE_BITS-1:0] value);
    logic [VALUE_BITS-1:0] rest;
    logic [VALUE_BITS-1:0] base;
    int                    digs [64];
    int                    n;
    int                    k;
    base = VALUE_BITS'(model_radix);
    if (base < RADIX_MIN) base = VALUE_BITS'(RADIX_MIN);
    if (base > MAX_RADIX) base = VALUE_BITS'(MAX_RADIX);
    rest = value;
    n = 0;
    if (rest == 0) begin
      queue_char(digit_char_of(0), 1'b1);
      return;
    end
    while (rest != 0) begin
      digs[n] = int'(rest % base);
      rest = rest / base;
      n++;
    end
    for (k = n - 1; k >= 0; k--) queue_char(digit_char_of(digs[k]), k == 0);
  endfunction

  function automatic logic [63:0] random_word();
    logic [63:0] w;
    int          kind;
    int          nbits;
    kind = $urandom_range(0, 9);
    w = {$urandom(), $urandom()};
    if (kind == 0) begin
      w[62:0] = '0;
    end else if (kind == 1) begin
      w[62:0] = '1;
    end else if (kind == 2) begin
      w[62:0] = 63'($urandom_range(0, 40));
    end else begin
      nbits = $urandom_range(1, 63);
      w[62:0] = w[62:0] & ((63'd1 << nbits) - 63'd1);
    end
    w[63] = 1'($urandom_range(0, 1));
    return w;
  endfunction

  task automatic load_setting(input setting_t s);
    int idx;
    cfg_we <= 1'b1;
    cfg_index <= REG_RADIX;
    cfg_data <= CFG_DATA_BITS'(s.radix);
    @(posedge clk);
    for (idx = 0; idx < 4; idx++) begin
      cfg_index <= CFG_INDEX_BITS'(REG_ALPHA0 + idx);
      cfg_data <= s.alpha[idx*CFG_DATA_BITS +: CFG_DATA_BITS];
      @(posedge clk);
    end
    if (s.junk) begin
      for (idx = REG_ALPHA3 + 1; idx < (1 << CFG_INDEX_BITS); idx++) begin
        cfg_index <= CFG_INDEX_BITS'(idx);
        cfg_data <= {$urandom(), $urandom()};
        @(posedge clk);
      end
    end
    cfg_we <= 1'b0;
    model_radix = s.radix;
    model_alpha = s.alpha;
  endtask

  task automatic send_word(input logic [63:0] word, input int typed_n,
                           input logic [CHAR_BITS-1:0] typed_ch, input bit stop);
    int k;
    int gap;
    s_tvalid <= 1'b1;
    s_tdata <= word;
    do @(posedge clk); while (!s_tready);
    if (typed_n == 0) begin
      predict_digits(word[VALUE_BITS-1:0]);
    end else begin
      for (k = 0; k < typed_n; k++) queue_char(typed_ch, k == typed_n - 1);
    end
    gap = sender_calm ? 0 : pick_gap();
    if (stop && gap == 0) gap = 1;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_chars.size() == 0) begin
        bad_chars++;
        if (bad_chars <= 10) $display("unexpected transfer: char %h last %b", m_tdata, m_tlast);
      end else begin
        want = expected_chars.pop_front();
        if (m_tdata !== want.ch || m_tlast !== want.last) begin
          bad_chars++;
          if (bad_chars <= 10)
            $display("mismatch: char exp %h got %h, last exp %b got %b",
                     want.ch, m_tdata, want.last, m_tlast);
        end
      end
    end
  end

  initial begin
    int  run;
    int  gap;
    bit  calm;
    bit  hold_done;
    calm = 1'b0;
    hold_done = 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 15) == 0) calm = !calm;
      run = calm ? $urandom_range(30, 150) : $urandom_range(1, 6);
      repeat (run) @(posedge clk);
      gap = calm ? 0 : pick_gap();
      if (want_long_hold && !hold_done) begin
        gap = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin
    #60_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int       r;
    int       p;
    int       i;
    int       cur;
    bit       stop;
    setting_t s;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    cur = 0;
    for (r = 0; r < 25; r++) begin
      if (rows[r].cfg != cur) begin
        drain();
        cur = rows[r].cfg;
        load_setting(presets[cur]);
      end
      stop = 1'b1;
      if (r < 24) stop = rows[r + 1].cfg != rows[r].cfg;
      send_word(rows[r].word, rows[r].typed_n, rows[r].typed_ch, stop);
    end

    for (p = 0; p < 8; p++) begin
      drain();
      s.radix = ($urandom_range(0, 4) == 0) ? RADIX_BITS'($urandom_range(0, 63))
                                            : RADIX_BITS'($urandom_range(2, 32));
      s.alpha = {$urandom(), $urandom(), $urandom(), $urandom(),
                 $urandom(), $urandom(), $urandom(), $urandom()};
      s.junk = 1'($urandom_range(0, 1));
      load_setting(s);
      sender_calm = ($urandom_range(0, 3) == 0);
      if (p == 0) want_long_hold = 1'b1;
      for (i = 0; i < 30; i++) send_word(random_word(), 0, 8'h00, i == 29);
    end

    while (expected_chars.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (bad_chars == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
